// ===== hdl/mppd_pkg.sv =====
// ----------------------------------------------------------------------------
// mppd_pkg
// shared types and constants for the mono polynomial predictor decoder
// ----------------------------------------------------------------------------
package mppd_pkg;

  localparam int SUM_WIDTH     = 48;
  localparam int LOG_FRAC_BITS = 16;
  localparam int LG_WIDTH      = 6 + LOG_FRAC_BITS;
  // front queue depth, at least 2
  localparam int QDEPTH        = 2;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int QIDX_W        = $clog2(QDEPTH);

  localparam logic [2:0]  MODE_HEADER = 3'd4;
  localparam logic [15:0] M_RESET     = 16'd100;

  localparam logic CMD_RESIDUAL = 1'b0;
  localparam logic CMD_HEADER   = 1'b1;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WINDOW = 3'd1;

  // item handed from front to back
  typedef struct packed {
    logic                 is_hdr;
    logic [19:0]          residual;
    logic [1:0]           hdr_predictor;
    logic [15:0]          hdr_golomb_m;
    logic [31:0]          hdr_sum_seed;
  } mppd_item_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        sample_valid;
    logic [15:0] golomb_m;
  } mppd_result_t;

endpackage

// ===== hdl/mono_polynomial_predictor_decoder.sv =====
// the front queue register and the held output register lie between an input transfer and its result;
// an item that closes a window with a nonzero sum also runs two 16-step logs and a 17-step divide
// the held result stalls the back end until popped; no new item is taken until the logs and divide end
// reset: synchronous active-low rst_n clears queue, history, sum, window count; m = 100
// ----------------------------------------------------------------------------
// mono_polynomial_predictor_decoder
// rebuilds mono samples from residuals with adaptive golomb parameter
// ----------------------------------------------------------------------------
module mono_polynomial_predictor_decoder
  import mppd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               in_cmd,
  input  logic signed [19:0] in_residual,
  input  logic [1:0]         in_hdr_predictor,
  input  logic [15:0]        in_hdr_golomb_m,
  input  logic [31:0]        in_hdr_sum_seed,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_sample,
  output logic               out_sample_valid,
  output logic [15:0]        out_golomb_m
);

  logic [2:0]   mode_r;
  logic [15:0]  win_r;
  logic         q_valid, q_take;
  mppd_item_t   q_item;
  mppd_result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'd1;
      win_r  <= 16'd256;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE)   mode_r <= cfg_data[2:0];
      if (cfg_index == REG_WINDOW) win_r  <= cfg_data;
    end
  end

  mppd_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode_r),
    .cmd(in_cmd), .residual(in_residual), .hdr_predictor(in_hdr_predictor),
    .hdr_golomb_m(in_hdr_golomb_m), .hdr_sum_seed(in_hdr_sum_seed),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  mppd_back u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r), .window_length(win_r),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .empty(empty), .pop(pop), .res(res)
  );

  assign out_sample       = res.sample;
  assign out_sample_valid = res.sample_valid;
  assign out_golomb_m     = res.golomb_m;

endmodule

// ===== hdl/mppd_front.sv =====
// ----------------------------------------------------------------------------
// mppd_front
// accepts input items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module mppd_front
  import mppd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       mode,
  input  logic             cmd,
  input  logic [19:0]      residual,
  input  logic [1:0]       hdr_predictor,
  input  logic [15:0]      hdr_golomb_m,
  input  logic [31:0]      hdr_sum_seed,
  output logic             q_valid,
  output mppd_item_t       q_item,
  input  logic             q_take
);

  mppd_item_t q_r [QDEPTH];
  mppd_item_t q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic       acc;
  mppd_item_t in_item;

  always_comb begin
    in_item.is_hdr        = (cmd == CMD_HEADER);
    in_item.residual      = residual;
    in_item.hdr_predictor = hdr_predictor;
    // headers are only acted on in header mode, else they just report m
    in_item.hdr_golomb_m  = (hdr_golomb_m == 16'd0) ? 16'd1 : hdr_golomb_m;
    in_item.hdr_sum_seed  = hdr_sum_seed;
    if (mode != MODE_HEADER) begin
      in_item.hdr_predictor = 2'd0;
    end
  end

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign acc     = push && !full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[0];

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (q_take && q_valid) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_nxt - QCNT_W'(1);
    end
    if (acc) begin
      q_nxt[cnt_nxt[QIDX_W-1:0]] = in_item;
      cnt_nxt                    = cnt_nxt + QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/mppd_log.sv =====
// ----------------------------------------------------------------------------
// mppd_log
// iterative fixed point log2, one squaring per cycle
// ----------------------------------------------------------------------------
module mppd_log
  import mppd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         x,
  output logic                done,
  output logic [LG_WIDTH-1:0] lg
);

  logic [31:0] y_r, y_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [LOG_FRAC_BITS-1:0] f_r, f_nxt;
  logic [4:0]  it_r, it_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0] sq;
  logic [5:0]  lead;
  logic [63:0] norm;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) lead = 6'(i);
    end
  end

  always_comb begin
    if (lead >= 6'd31) norm = x >> (lead - 6'd31);
    else               norm = x << (6'd31 - lead);
  end

  // y stays below 2^32 between steps
  assign sq = 64'(y_r) * 64'(y_r);

  always_comb begin
    y_nxt = y_r; e_nxt = e_r; f_nxt = f_r; it_nxt = it_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      y_nxt = norm[31:0]; e_nxt = lead; f_nxt = '0; it_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      f_nxt = {f_r[LOG_FRAC_BITS-2:0], 1'b0};
      if (sq[63:31] >= 33'h1_0000_0000) begin
        f_nxt[0] = 1'b1;
        y_nxt    = sq[63:32];
      end else begin
        y_nxt = sq[62:31];
      end
      it_nxt = it_r + 5'd1;
      if (it_r == 5'(LOG_FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt; e_r <= e_nxt; f_r <= f_nxt; it_r <= it_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign lg   = {e_r, f_r};

endmodule

// ===== hdl/mppd_back.sv =====
// ----------------------------------------------------------------------------
// mppd_back
// sample rebuild, magnitude sum and golomb parameter update sequencer
// ----------------------------------------------------------------------------
module mppd_back
  import mppd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    mode,
  input  logic [15:0]   window_length,
  input  logic          q_valid,
  input  mppd_item_t    q_item,
  output logic          q_take,
  output logic          empty,
  input  logic          pop,
  output mppd_result_t  res
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LG_T = 6'b000010,
    ST_WAIT = 6'b000100,
    ST_LG_S = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } st_t;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  st_t st_r, st_nxt;
  logic [15:0] h0_r, h1_r, h2_r, h0_nxt, h1_nxt, h2_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic [16:0] wc_r, wc_nxt;
  logic [15:0] m_r, m_nxt;
  logic [1:0]  ap_r, ap_nxt;
  mppd_result_t out_r, out_nxt;
  logic        full_r, full_nxt;
  logic [LG_WIDTH-1:0] lgt_r, lgt_nxt;
  logic [LG_WIDTH-1:0] l_r, l_nxt;
  logic [LOG_FRAC_BITS:0] rem_r, rem_nxt;
  logic [LOG_FRAC_BITS:0] quo_r, quo_nxt;
  logic [LOG_FRAC_BITS:0] dvd_r, dvd_nxt;
  logic [4:0]  dc_r, dc_nxt;
  logic        lg_start;
  logic [63:0] lg_x;
  logic        lg_done;
  logic [LG_WIDTH-1:0] lg_val;

  logic [1:0]  order;
  logic [15:0] s;
  logic [19:0] mag;
  logic [16:0] weff;
  logic [SUM_WIDTH-1:0] sum_acc;
  logic [64:0] tsum;
  logic [LG_WIDTH-1:0] l_cur;
  logic [LOG_FRAC_BITS+1:0] trial;
  logic [LOG_FRAC_BITS+1:0] dsor;
  logic        q_bit;
  logic [15:0] m_div;

  mppd_log u_log (
    .clk(clk), .rst_n(rst_n), .start(lg_start), .x(lg_x), .done(lg_done), .lg(lg_val)
  );

  always_comb begin
    if (mode == MODE_HEADER)     order = ap_r;
    else if (mode < MODE_HEADER) order = mode[1:0];
    else                         order = 2'd3;
  end

  always_comb begin
    unique case (order)
      2'd0:    s = q_item.residual[15:0];
      2'd1:    s = q_item.residual[15:0] + h0_r;
      2'd2:    s = q_item.residual[15:0] + {h0_r[14:0], 1'b0} - h1_r;
      default: s = q_item.residual[15:0] + 16'(3 * h0_r) - 16'(3 * h1_r) + h2_r;
    endcase
  end

  assign mag  = q_item.residual[19] ? (20'd0 - q_item.residual) : q_item.residual;
  assign weff = (window_length == 16'd0) ? 17'h10000 : {1'b0, window_length};
  assign sum_acc = ((SUM_MAX - sum_r) < SUM_WIDTH'(mag)) ? SUM_MAX
                   : sum_r + SUM_WIDTH'(mag);
  assign tsum = 65'(sum_r) + 65'(weff);

  // restoring divide of 2^F + l - 1 by l, one quotient bit per cycle
  assign l_cur = lgt_r - lg_val;
  assign trial = {rem_r, dvd_r[LOG_FRAC_BITS]};
  assign dsor  = {1'b0, l_r[LOG_FRAC_BITS:0]};
  assign q_bit = (trial >= dsor);
  assign m_div = (quo_r > (LOG_FRAC_BITS+1)'(16'hFFFF)) ? 16'hFFFF : 16'(quo_r);

  assign q_take = (st_r == ST_IDLE) && q_valid && !full_r;
  assign empty  = !full_r;
  assign res    = out_r;

  always_comb begin
    st_nxt = st_r;
    h0_nxt = h0_r; h1_nxt = h1_r; h2_nxt = h2_r;
    sum_nxt = sum_r; wc_nxt = wc_r; m_nxt = m_r; ap_nxt = ap_r;
    out_nxt = out_r; full_nxt = full_r;
    lgt_nxt = lgt_r; l_nxt = l_r; rem_nxt = rem_r; quo_nxt = quo_r; dc_nxt = dc_r;
    dvd_nxt = dvd_r;
    lg_start = 1'b0;
    lg_x = tsum[64] ? '1 : tsum[63:0];
    if (full_r && pop) full_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          if (q_item.is_hdr) begin
            if (mode == MODE_HEADER) begin
              ap_nxt  = q_item.hdr_predictor;
              m_nxt   = q_item.hdr_golomb_m;
              sum_nxt = SUM_WIDTH'(q_item.hdr_sum_seed);
              out_nxt = '{sample: 16'd0, sample_valid: 1'b0,
                          golomb_m: q_item.hdr_golomb_m};
            end else begin
              out_nxt = '{sample: 16'd0, sample_valid: 1'b0, golomb_m: m_r};
            end
            full_nxt = 1'b1;
          end else begin
            h0_nxt = s; h1_nxt = h0_r; h2_nxt = h1_r;
            out_nxt.sample = s; out_nxt.sample_valid = 1'b1;
            if ((wc_r + 17'd1) >= weff) begin
              wc_nxt = '0;
              if (sum_acc == '0) begin
                m_nxt = 16'd1; out_nxt.golomb_m = 16'd1; sum_nxt = '0; full_nxt = 1'b1;
              end else begin
                sum_nxt = sum_acc;
                st_nxt  = ST_LG_T;
              end
            end else begin
              wc_nxt = wc_r + 17'd1;
              sum_nxt = sum_acc;
              out_nxt.golomb_m = m_r;
              full_nxt = 1'b1;
            end
          end
        end
      end
      ST_LG_T: begin
        lg_start = 1'b1;
        st_nxt   = ST_WAIT;
      end
      ST_WAIT: begin
        if (lg_done) begin
          lgt_nxt  = lg_val;
          lg_x     = 64'(sum_r);
          lg_start = 1'b1;
          st_nxt   = ST_LG_S;
        end
      end
      ST_LG_S: begin
        lg_x = 64'(sum_r);
        if (lg_done) begin
          l_nxt   = l_cur;
          dvd_nxt = {1'b1, {LOG_FRAC_BITS{1'b0}}} + {1'b0, l_cur[LOG_FRAC_BITS-1:0]}
                    - {{LOG_FRAC_BITS{1'b0}}, 1'b1};
          rem_nxt = '0; quo_nxt = '0; dc_nxt = '0;
          st_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? (trial[LOG_FRAC_BITS:0] - dsor[LOG_FRAC_BITS:0])
                        : trial[LOG_FRAC_BITS:0];
        quo_nxt = {quo_r[LOG_FRAC_BITS-1:0], q_bit};
        dvd_nxt = {dvd_r[LOG_FRAC_BITS-1:0], 1'b0};
        dc_nxt  = dc_r + 5'd1;
        if (dc_r == 5'(LOG_FRAC_BITS)) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        // l of zero gives the top m, l of at least one gives m of one
        if (l_r == '0) begin
          m_nxt = 16'hFFFF;
        end else if (l_r[LG_WIDTH-1:LOG_FRAC_BITS] != '0) begin
          m_nxt = 16'd1;
        end else begin
          m_nxt = m_div;
        end
        out_nxt.golomb_m = m_nxt;
        sum_nxt  = '0;
        full_nxt = 1'b1;
        st_nxt   = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt; lgt_r <= lgt_nxt; l_r <= l_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; dc_r <= dc_nxt; dvd_r <= dvd_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE; sum_r <= '0; wc_r <= '0; m_r <= M_RESET; ap_r <= 2'd0;
      h0_r <= '0; h1_r <= '0; h2_r <= '0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sum_r <= sum_nxt; wc_r <= wc_nxt; m_r <= m_nxt; ap_r <= ap_nxt;
      h0_r <= h0_nxt; h1_r <= h1_nxt; h2_r <= h2_nxt;
      full_r <= full_nxt;
    end
  end

endmodule
